/* sv/fpa_pkg.sv */
package fpa_pkg;

    localparam int unsigned NumPartitions = 7;
    localparam int unsigned QueueDepth    = 8;

    localparam int unsigned ActionW = 2;
    localparam int unsigned IdW     = 8;
    localparam int unsigned SizeW   = 16;
    localparam int unsigned StatusW = 3;
    localparam int unsigned IndexW  = 3;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned WaitW   = IdW + SizeW;

    localparam logic [ActionW-1:0] ACT_FIRST = 2'd0;
    localparam logic [ActionW-1:0] ACT_BEST  = 2'd1;
    localparam logic [ActionW-1:0] ACT_FREE  = 2'd2;

    localparam logic [StatusW-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [StatusW-1:0] ST_QUEUED    = 3'd1;
    localparam logic [StatusW-1:0] ST_FREED     = 3'd2;
    localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [StatusW-1:0] ST_REJECTED  = 3'd4;

    localparam logic [CfgIdxW-1:0] REG_IN_USE = 3'd0;

    typedef struct packed {
        logic [ActionW-1:0] action;
        logic [IdW-1:0]     proc_id;
        logic [SizeW-1:0]   process_size;
    } t_req;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [IdW-1:0]     owner_id;
        logic [IndexW-1:0]  partition_index;
        logic               last;
    } t_rsp;

endpackage

/* sv/fpa_req_if.sv */
interface fpa_req_if;
    logic          valid;
    logic          ready;
    fpa_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/fpa_rsp_if.sv */
interface fpa_rsp_if;
    logic          valid;
    logic          ready;
    fpa_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/fixed_partition_allocator_core.sv */
// Steps: allocate, S_DECIDE and then the result in S_OUT1; free, S_DECIDE, then S_READ and
// S_CHECK per waiting entry scanned, S_SHIFT per entry shifted down, then S_OUT1 and S_OUT2 for
// a second result when placed. Flow: one request at a time, the next taken in S_IDLE after the
// last result transfer; the wait queue RAM's single read port sets the scan rate; removal shifts
// one entry per cycle.
// Reset (i_rst_n synchronous, active low): partitions free, queue empty, config at defaults.
module fixed_partition_allocator_core #(
    parameter int unsigned NumPartitions = fpa_pkg::NumPartitions,
    parameter int unsigned QueueDepth    = fpa_pkg::QueueDepth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fpa_req_if.sink                      req,
    fpa_rsp_if.source                    rsp,
    input  logic                         i_cfg_we,
    input  logic [fpa_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [fpa_pkg::CfgDataW-1:0] i_cfg_data
);
    localparam int unsigned QAW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned QCW = $clog2(QueueDepth + 1);
    localparam int unsigned PW  = fpa_pkg::IndexW;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_READ  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_OUT1  = 7'b0100000,
        S_OUT2  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [2:0]                   r_in_use;
    logic [fpa_pkg::SizeW-1:0]    r_psize [NumPartitions];
    logic [NumPartitions-1:0]     r_busy;
    logic [fpa_pkg::IdW-1:0]      r_owner [NumPartitions];
    logic [QCW-1:0]               r_wcount;

    fpa_pkg::t_req                r_req;
    fpa_pkg::t_rsp                r_rsp0, r_rsp1;
    logic                         r_two;
    logic [QAW-1:0]               r_ptr;

    // active mask
    logic [NumPartitions-1:0] act;
    always_comb begin
        for (int i = 0; i < NumPartitions; i++) begin
            act[i] = (i < int'(r_in_use));
        end
    end

    // first fit and best fit on a given size
    function automatic logic [NumPartitions:0] fit_first(
        input logic [fpa_pkg::SizeW-1:0] need,
        input logic [NumPartitions-1:0] busy, input logic [NumPartitions-1:0] a,
        input logic [fpa_pkg::SizeW-1:0] sz [NumPartitions]);
        logic [NumPartitions:0] res;
        res = '0;
        for (int i = NumPartitions - 1; i >= 0; i--) begin
            if (a[i] && !busy[i] && sz[i] >= need) begin
                res = {1'b1, NumPartitions'(0)} | (NumPartitions+1)'(i);
            end
        end
        return res;
    endfunction

    logic [NumPartitions:0] ff_req, ff_wait;
    logic                   bf_ok;
    logic [PW-1:0]          bf_idx;
    logic [fpa_pkg::SizeW-1:0] bf_sz;
    logic [fpa_pkg::WaitW-1:0] w_rdata;
    logic [fpa_pkg::SizeW-1:0] w_size;
    logic [fpa_pkg::IdW-1:0]   w_id;
    assign w_id   = w_rdata[fpa_pkg::WaitW-1:fpa_pkg::SizeW];
    assign w_size = w_rdata[fpa_pkg::SizeW-1:0];

    assign ff_req  = fit_first(r_req.process_size, r_busy, act, r_psize);
    assign ff_wait = fit_first(w_size, r_busy, act, r_psize);

    always_comb begin
        bf_ok  = 1'b0;
        bf_idx = '0;
        bf_sz  = '0;
        for (int i = 0; i < NumPartitions; i++) begin
            if (act[i] && !r_busy[i] && r_psize[i] >= r_req.process_size
                && (!bf_ok || r_psize[i] < bf_sz)) begin
                bf_ok  = 1'b1;
                bf_idx = PW'(i);
                bf_sz  = r_psize[i];
            end
        end
    end

    logic               fr_ok;
    logic [PW-1:0]      fr_idx;
    always_comb begin
        fr_ok  = 1'b0;
        fr_idx = '0;
        for (int i = NumPartitions - 1; i >= 0; i--) begin
            if (act[i] && r_busy[i] && r_owner[i] == r_req.proc_id) begin
                fr_ok  = 1'b1;
                fr_idx = PW'(i);
            end
        end
    end

    // queue RAM
    logic                       q_we;
    logic [QAW-1:0]             q_waddr, q_raddr;
    logic [fpa_pkg::WaitW-1:0]  q_wdata;

    fpa_ram #(.Width(fpa_pkg::WaitW), .Depth(QueueDepth)) u_queue (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(q_waddr),
        .i_wdata(q_wdata),
        .i_raddr(q_raddr),
        .o_rdata(w_rdata)
    );

    logic req_fire, rsp_fire;
    assign req.ready = (r_state == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = rsp.valid && rsp.ready;
    assign rsp.valid = (r_state == S_OUT1) || (r_state == S_OUT2);
    assign rsp.payload = (r_state == S_OUT2) ? r_rsp1 : r_rsp0;

    logic [QAW-1:0] tail;
    assign tail = QAW'(r_wcount);
    logic [QAW:0] ptr_next;
    assign ptr_next = {1'b0, r_ptr} + 1'b1;

    always_comb begin
        n_state = r_state;
        q_we    = 1'b0;
        q_waddr = r_ptr;
        q_wdata = w_rdata;
        q_raddr = r_ptr;
        case (r_state)
            S_IDLE:   if (req_fire) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_req.action == fpa_pkg::ACT_FREE) begin
                    n_state = (fr_ok && r_wcount != '0) ? S_READ : S_OUT1;
                end else if (r_req.action == fpa_pkg::ACT_FIRST
                             || r_req.action == fpa_pkg::ACT_BEST) begin
                    n_state = S_OUT1;
                    if (!(r_req.action == fpa_pkg::ACT_FIRST ? ff_req[NumPartitions] : bf_ok)
                        && r_wcount < QCW'(QueueDepth)) begin
                        q_we    = 1'b1;
                        q_waddr = tail;
                        q_wdata = {r_req.proc_id, r_req.process_size};
                    end
                end else begin
                    n_state = S_IDLE;
                end
                q_raddr = '0;
            end
            S_READ:   n_state = S_CHECK;
            S_CHECK: begin
                if (ff_wait[NumPartitions]) begin
                    n_state = S_SHIFT;
                    q_raddr = QAW'(ptr_next);
                end else if (ptr_next >= (QAW+1)'(r_wcount)) begin
                    n_state = S_OUT1;
                end else begin
                    n_state = S_READ;
                    q_raddr = QAW'(ptr_next);
                end
            end
            S_SHIFT: begin
                // read data of ptr+1 arrives now; move it down one slot
                if (ptr_next >= (QAW+1)'(r_wcount)) begin
                    n_state = S_OUT1;
                end else begin
                    q_we    = 1'b1;
                    q_waddr = r_ptr;
                    q_wdata = w_rdata;
                    q_raddr = QAW'(ptr_next + 1'b1);
                end
            end
            S_OUT1: if (rsp_fire) n_state = r_two ? S_OUT2 : S_IDLE;
            S_OUT2: if (rsp_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_use   <= 3'd7;
            r_busy     <= '0;
            r_wcount   <= '0;
            r_two      <= 1'b0;
            r_ptr      <= '0;
            for (int i = 0; i < NumPartitions; i++) begin
                r_psize[i] <= '0;
                r_owner[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == fpa_pkg::REG_IN_USE) begin
                    r_in_use <= (i_cfg_data[2:0] > 3'(NumPartitions))
                              ? 3'(NumPartitions) : i_cfg_data[2:0];
                end else if (int'(i_cfg_index) <= NumPartitions) begin
                    r_psize[i_cfg_index - 3'd1] <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: if (req_fire) r_req <= req.payload;
                S_DECIDE: begin
                    r_two <= 1'b0;
                    r_ptr <= '0;
                    r_rsp0.owner_id <= r_req.proc_id;
                    r_rsp0.last     <= 1'b1;
                    r_rsp0.partition_index <= '0;
                    if (r_req.action == fpa_pkg::ACT_FREE) begin
                        if (fr_ok) begin
                            r_busy[fr_idx]  <= 1'b0;
                            r_owner[fr_idx] <= '0;
                            r_rsp0.status <= fpa_pkg::ST_FREED;
                            r_rsp0.partition_index <= fr_idx;
                        end else begin
                            r_rsp0.status <= fpa_pkg::ST_NOT_FOUND;
                        end
                    end else if (r_req.action == fpa_pkg::ACT_FIRST
                                 || r_req.action == fpa_pkg::ACT_BEST) begin
                        if (r_req.action == fpa_pkg::ACT_FIRST ? ff_req[NumPartitions] : bf_ok)
                        begin
                            r_rsp0.status <= fpa_pkg::ST_ALLOCATED;
                            r_rsp0.partition_index <= (r_req.action == fpa_pkg::ACT_FIRST)
                                ? PW'(ff_req[NumPartitions-1:0]) : bf_idx;
                            r_busy[(r_req.action == fpa_pkg::ACT_FIRST)
                                ? PW'(ff_req[NumPartitions-1:0]) : bf_idx] <= 1'b1;
                            r_owner[(r_req.action == fpa_pkg::ACT_FIRST)
                                ? PW'(ff_req[NumPartitions-1:0]) : bf_idx] <= r_req.proc_id;
                        end else if (r_wcount < QCW'(QueueDepth)) begin
                            r_rsp0.status <= fpa_pkg::ST_QUEUED;
                            r_wcount <= r_wcount + 1'b1;
                        end else begin
                            r_rsp0.status <= fpa_pkg::ST_REJECTED;
                        end
                    end
                end
                S_CHECK: begin
                    if (ff_wait[NumPartitions]) begin
                        r_busy[PW'(ff_wait[NumPartitions-1:0])]  <= 1'b1;
                        r_owner[PW'(ff_wait[NumPartitions-1:0])] <= w_id;
                        r_two <= 1'b1;
                        r_rsp0.last <= 1'b0;
                        r_rsp1.status <= fpa_pkg::ST_ALLOCATED;
                        r_rsp1.owner_id <= w_id;
                        r_rsp1.partition_index <= PW'(ff_wait[NumPartitions-1:0]);
                        r_rsp1.last <= 1'b1;
                    end else begin
                        r_ptr <= QAW'(ptr_next);
                    end
                end
                S_SHIFT: begin
                    // the queue shrinks once, when the shift reaches the tail
                    if (ptr_next >= (QAW+1)'(r_wcount)) begin
                        r_wcount <= r_wcount - 1'b1;
                    end else begin
                        r_ptr <= QAW'(ptr_next);
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcount <= QCW'(QueueDepth)) else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT2) |-> r_two) else $error("second result without pair");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_wcount != '0)) else $error("scan of empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid |-> !req.ready) else $error("request taken during result");
endmodule

/* sv/fpa_ram.sv */
module fpa_ram #(
    parameter int unsigned Width = 24,
    parameter int unsigned Depth = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam logic [fpa_pkg::ActionW-1:0] ACT_NONE = 2'd3;
    localparam int unsigned TailCycles = 2 * fpa_pkg::QueueDepth + 24;

    typedef struct {
        logic [fpa_pkg::IdW-1:0]   id;
        logic [fpa_pkg::SizeW-1:0] size;
    } t_held_req;

    // Tracks the allocator state and the results still owed by the block.
    class alloc_scoreboard;
        logic [fpa_pkg::CfgIdxW-1:0] in_use = 3'd7;
        logic [fpa_pkg::SizeW-1:0]   part_size [fpa_pkg::NumPartitions];
        bit                          busy [fpa_pkg::NumPartitions];
        logic [fpa_pkg::IdW-1:0]     owner [fpa_pkg::NumPartitions];
        t_held_req                   waiting [$];
        fpa_pkg::t_rsp               owed [$];
        int unsigned                 mismatches;

        function new();
            foreach (part_size[i]) begin
                part_size[i] = '0;
                busy[i] = 0;
                owner[i] = '0;
            end
        endfunction

        function void write_reg(logic [fpa_pkg::CfgIdxW-1:0] idx,
                                logic [fpa_pkg::CfgDataW-1:0] data);
            if (idx == fpa_pkg::REG_IN_USE) begin
                in_use = data[fpa_pkg::CfgIdxW-1:0];
            end else begin
                part_size[idx - 1] = data;
            end
        endfunction

        function int unsigned parts();
            return (in_use > fpa_pkg::NumPartitions) ? fpa_pkg::NumPartitions : in_use;
        endfunction

        function int first_fit(logic [fpa_pkg::SizeW-1:0] need);
            for (int i = 0; i < parts(); i++) begin
                if (!busy[i] && part_size[i] >= need) return i;
            end
            return -1;
        endfunction

        function int best_fit(logic [fpa_pkg::SizeW-1:0] need);
            int pick;
            pick = -1;
            for (int i = 0; i < parts(); i++) begin
                if (!busy[i] && part_size[i] >= need &&
                    (pick < 0 || part_size[i] < part_size[pick])) pick = i;
            end
            return pick;
        endfunction

        function void owe(logic [fpa_pkg::StatusW-1:0] st, logic [fpa_pkg::IdW-1:0] id,
                          int idx, bit fin);
            fpa_pkg::t_rsp r;
            r.status = st;
            r.owner_id = id;
            r.partition_index = idx[fpa_pkg::IndexW-1:0];
            r.last = fin;
            owed.push_back(r);
        endfunction

        function void note_request(fpa_pkg::t_req q);
            int p;
            int freed;
            t_held_req h;
            case (q.action)
                fpa_pkg::ACT_FIRST, fpa_pkg::ACT_BEST: begin
                    p = (q.action == fpa_pkg::ACT_FIRST) ? first_fit(q.process_size)
                                                         : best_fit(q.process_size);
                    if (p >= 0) begin
                        busy[p] = 1;
                        owner[p] = q.proc_id;
                        owe(fpa_pkg::ST_ALLOCATED, q.proc_id, p, 1);
                    end else if (waiting.size() < fpa_pkg::QueueDepth) begin
                        h.id = q.proc_id;
                        h.size = q.process_size;
                        waiting.push_back(h);
                        owe(fpa_pkg::ST_QUEUED, q.proc_id, 0, 1);
                    end else begin
                        owe(fpa_pkg::ST_REJECTED, q.proc_id, 0, 1);
                    end
                end
                fpa_pkg::ACT_FREE: begin
                    freed = -1;
                    for (int i = 0; i < parts(); i++) begin
                        if (freed < 0 && busy[i] && owner[i] == q.proc_id) freed = i;
                    end
                    if (freed < 0) begin
                        owe(fpa_pkg::ST_NOT_FOUND, q.proc_id, 0, 1);
                        return;
                    end
                    busy[freed] = 0;
                    owner[freed] = '0;
                    // place only the oldest waiter that now fits
                    foreach (waiting[w]) begin
                        p = first_fit(waiting[w].size);
                        if (p >= 0) begin
                            busy[p] = 1;
                            owner[p] = waiting[w].id;
                            owe(fpa_pkg::ST_FREED, q.proc_id, freed, 0);
                            owe(fpa_pkg::ST_ALLOCATED, waiting[w].id, p, 1);
                            waiting.delete(w);
                            return;
                        end
                    end
                    owe(fpa_pkg::ST_FREED, q.proc_id, freed, 1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(fpa_pkg::t_rsp got);
            fpa_pkg::t_rsp want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status || got.owner_id !== want.owner_id ||
                got.partition_index !== want.partition_index || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [fpa_pkg::CfgIdxW-1:0] cfg_index = '0;
    logic [fpa_pkg::CfgDataW-1:0] cfg_data = '0;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    alloc_scoreboard sb = new();

    fpa_req_if req_ch ();
    fpa_rsp_if rsp_ch ();

    fixed_partition_allocator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req        (req_ch.sink),
        .rsp        (rsp_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        if (i_rst_n && req_ch.valid && req_ch.ready) sb.note_request(req_ch.payload);
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
    end

    task automatic send_req(fpa_pkg::t_req q);
        while ($urandom_range(99) < snd_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= q;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic send(logic [fpa_pkg::ActionW-1:0] act, logic [fpa_pkg::IdW-1:0] id,
                        logic [fpa_pkg::SizeW-1:0] sz);
        fpa_pkg::t_req q;
        q.action = act;
        q.proc_id = id;
        q.process_size = sz;
        send_req(q);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
    endtask

    // leaves the write enable high; configure drops it after the last write
    task automatic write_reg(logic [fpa_pkg::CfgIdxW-1:0] idx,
                             logic [fpa_pkg::CfgDataW-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(int unsigned kind);
        logic [fpa_pkg::SizeW-1:0] sz [fpa_pkg::NumPartitions];
        logic [fpa_pkg::CfgIdxW-1:0] n;
        n = 3'd7;
        foreach (sz[i]) begin
            case (kind)
                0: sz[i] = (i == 6) ? 16'hFFFF : 16'(10 * (i + 1));
                2: sz[i] = (i == 0) ? 16'd0 : 16'd5;
                3: sz[i] = 16'($urandom_range(100));
                4: sz[i] = (i == 0) ? 16'hFFFF : 16'd1;
                default: sz[i] = 16'($urandom_range(65535));
            endcase
        end
        case (kind)
            1: n = 3'd0;
            2: n = 3'd3;
            4: n = 3'd2;
            default: n = 3'd7;
        endcase
        write_reg(fpa_pkg::REG_IN_USE, fpa_pkg::CfgDataW'(n));
        foreach (sz[i]) write_reg(fpa_pkg::CfgIdxW'(i + 1), sz[i]);
        cfg_we <= 1'b0;
    endtask

    function automatic fpa_pkg::t_req random_req();
        fpa_pkg::t_req q;
        int unsigned r;
        r = $urandom_range(99);
        q.action = (r < 42) ? fpa_pkg::ACT_FIRST : (r < 62) ? fpa_pkg::ACT_BEST
                 : (r < 97) ? fpa_pkg::ACT_FREE : ACT_NONE;
        q.proc_id = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                             : 8'($urandom_range(7));
        case ($urandom_range(5))
            0: q.process_size = '0;
            1: q.process_size = 16'hFFFF;
            2: q.process_size = 16'($urandom_range(65535));
            default: begin
                r = sb.part_size[$urandom_range(fpa_pkg::NumPartitions - 1)]
                  + $urandom_range(4);
                q.process_size = (r < 2) ? '0 : (r > 65537) ? 16'hFFFF : 16'(r - 2);
            end
        endcase
        return q;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 33;
        rcv_idle_pct = 68;
        configure(0);
        send(fpa_pkg::ACT_FIRST, 8'd0, 16'd0);
        send(fpa_pkg::ACT_BEST, 8'd1, 16'd35);
        send(fpa_pkg::ACT_FIRST, 8'hFF, 16'hFFFF);
        send(fpa_pkg::ACT_BEST, 8'd2, 16'hFFFF);
        send(fpa_pkg::ACT_FREE, 8'd2, 16'd0);
        send(fpa_pkg::ACT_FREE, 8'hFF, 16'hFFFF);
        send(fpa_pkg::ACT_FIRST, 8'd1, 16'd5);
        send(fpa_pkg::ACT_FREE, 8'd1, 16'd0);
        send(ACT_NONE, 8'hAA, 16'h5555);
        for (int i = 0; i < 10; i++) send(fpa_pkg::ACT_FIRST, 8'(8 + i), 16'hFFFF);
        send(fpa_pkg::ACT_FREE, 8'd2, 16'd0);
        send(fpa_pkg::ACT_BEST, 8'h55, 16'hAAAA);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 68 : 0;
            rcv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 33 : 0;
            for (int blk = 0; blk < 5; blk++) begin
                configure((ph * 5 + blk + 1) % 6);
                for (int k = 0; k < 75; k++) send_req(random_req());
                drain();
            end
        end

        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
